[hw/rtl/hash_bucket_tag_match_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hash bucket tag match block
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HASH_BUCKET_TAG_MATCH_ASSERT_SVH
`define HASH_BUCKET_TAG_MATCH_ASSERT_SVH

`ifndef ASSERT_OFF
// Condition that must hold at every clock edge
`define HBTM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Same-cycle implication
`define HBTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define HBTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBTM_ASSERT(lbl, cond, msg)
`define HBTM_ASSERT_IMP(lbl, ante, cons, msg)
`define HBTM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/hbtm_pkg.sv]
// ----------------------------------------------------------------------------
// hbtm_pkg
// Operation and status codes plus the slot command bundle.
// ----------------------------------------------------------------------------
package hbtm_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } hbtm_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_NEXT = 2'd2,
    ST_NOT_OCC  = 2'd3
  } hbtm_status_e;

  // Per-cycle update command from control to the slot storage
  typedef struct packed {
    logic wr;   // insert key at target slot
    logic mv;   // copy last slot into target slot
    logic clr;  // clear all tags
  } slot_cmd_t;

endpackage

[hw/rtl/hash_bucket_tag_match.sv]
// ----------------------------------------------------------------------------
// hash_bucket_tag_match
// Slot bucket with tag plus full hash lookup, insert, swap-remove and clear.
//
//   channel  | valid      | ready      | payload
//   ---------+------------+------------+--------------------------------------
//   request  | in_valid_i | in_ready_o | op_i, slot_index_i, key_hash_i
//   response | out_valid_o| out_ready_i| status_o, match_index_o, fill_count_o,
//            |            |            | was_full_o
//
// One transfer per cycle sustained while out_ready_i is high. A request
// passes the input register, then compare/update into the response register.
// Bucket state updates as an item moves into the response register, so the
// next item sees it. A stalled response holds the input register, which then
// holds the request side. Reset clears count, flag, tags and valid bits.
// ----------------------------------------------------------------------------
`include "hash_bucket_tag_match_assert.svh"

module hash_bucket_tag_match import hbtm_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int TAG_WIDTH  = 7,
  parameter int HASH_WIDTH = 32,
  localparam int IdxW = $clog2(SLOTS),
  localparam int CntW = $clog2(SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [IdxW-1:0]       slot_index_i,
  input  logic [HASH_WIDTH-1:0] key_hash_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [CntW-1:0]       match_index_o,
  output logic [CntW-1:0]       fill_count_o,
  output logic                  was_full_o
);

  localparam logic [CntW-1:0] SlotsC = CntW'(SLOTS);

  logic                  in_vld_q, out_vld_q;
  logic [1:0]            op_q;
  logic [IdxW-1:0]       idx_q;
  logic [HASH_WIDTH-1:0] hash_q;
  logic                  adv;
  logic                  in_xfer;

  slot_cmd_t             cmd;
  logic [IdxW-1:0]       last;
  logic [CntW-1:0]       cnt;
  logic [SLOTS-1:0]      hit;
  logic [1:0]            status_d, status_q;
  logic [CntW-1:0]       match_d, match_q;
  logic [CntW-1:0]       fill_d, fill_q;
  logic                  full_d, full_q;

  // Pipeline flow control
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer)  in_vld_q <= 1'b1;
      else if (adv) in_vld_q <= 1'b0;
      if (adv)              out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // Request register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_i;
      idx_q  <= slot_index_i;
      hash_q <= key_hash_i;
    end
  end

  hbtm_slot_array #(
    .SLOTS      (SLOTS),
    .TAG_WIDTH  (TAG_WIDTH),
    .HASH_WIDTH (HASH_WIDTH)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx_q),
    .last_i     (last),
    .key_hash_i (hash_q),
    .cnt_i      (cnt),
    .hit_o      (hit)
  );

  hbtm_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .op_i     (op_q),
    .idx_i    (idx_q),
    .hit_i    (hit),
    .cmd_o    (cmd),
    .last_o   (last),
    .cnt_o    (cnt),
    .status_o (status_d),
    .match_o  (match_d),
    .fill_o   (fill_d),
    .full_o   (full_d)
  );

  // Response register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      match_q  <= match_d;
      fill_q   <= fill_d;
      full_q   <= full_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign match_index_o = match_q;
  assign fill_count_o  = fill_q;
  assign was_full_o    = full_q;

  // Checks
  `HBTM_ASSERT(a_cnt_range, cnt <= SlotsC, "fill count above slot count")
  `HBTM_ASSERT_NXT(a_err_keeps_cnt, adv && (status_d != ST_OK), cnt == $past(cnt),
                   "rejected operation changed fill count")
  `HBTM_ASSERT_IMP(a_full_flag, out_valid_o && (fill_count_o == SlotsC), was_full_o,
                   "full bucket without been-full flag")

endmodule

[hw/rtl/hbtm_slot_array.sv]
// ----------------------------------------------------------------------------
// hbtm_slot_array
// Per-slot tag and full hash storage with parallel key compare.
// ----------------------------------------------------------------------------
module hbtm_slot_array import hbtm_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int TAG_WIDTH  = 7,
  parameter int HASH_WIDTH = 32,
  localparam int IdxW = $clog2(SLOTS),
  localparam int CntW = $clog2(SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slot_cmd_t             cmd_i,
  input  logic [IdxW-1:0]       idx_i,
  input  logic [IdxW-1:0]       last_i,
  input  logic [HASH_WIDTH-1:0] key_hash_i,
  input  logic [CntW-1:0]       cnt_i,
  output logic [SLOTS-1:0]      hit_o
);

  logic [TAG_WIDTH-1:0]  tags_q   [SLOTS];
  logic [HASH_WIDTH-1:0] hashes_q [SLOTS];
  logic [TAG_WIDTH-1:0]  key_tag;

  assign key_tag = key_hash_i[TAG_WIDTH-1:0];

  // Tags: reset to zero, cleared by a bucket reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) tags_q[i] <= '0;
    end else if (cmd_i.clr) begin
      for (int i = 0; i < SLOTS; i++) tags_q[i] <= '0;
    end else if (cmd_i.wr) begin
      tags_q[idx_i] <= key_tag;
    end else if (cmd_i.mv) begin
      tags_q[idx_i] <= tags_q[last_i];
    end
  end

  // Full hashes: only occupied slots are ever compared, so no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      hashes_q[idx_i] <= key_hash_i;
    end else if (cmd_i.mv) begin
      hashes_q[idx_i] <= hashes_q[last_i];
    end
  end

  // One compare lane per slot, masked by occupancy
  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    localparam logic [CntW-1:0] SlotNum = CntW'(g);
    assign hit_o[g] = (SlotNum < cnt_i) && (tags_q[g] == key_tag)
                      && (hashes_q[g] == key_hash_i);
  end

endmodule

[hw/rtl/hbtm_ctrl.sv]
// ----------------------------------------------------------------------------
// hbtm_ctrl
// Fill count, been-full flag, operation checks and match priority encode.
// ----------------------------------------------------------------------------
module hbtm_ctrl import hbtm_pkg::*; #(
  parameter int SLOTS = 8,
  localparam int IdxW = $clog2(SLOTS),
  localparam int CntW = $clog2(SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [1:0]       op_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [SLOTS-1:0] hit_i,
  output slot_cmd_t        cmd_o,
  output logic [IdxW-1:0]  last_o,
  output logic [CntW-1:0]  cnt_o,
  output logic [1:0]       status_o,
  output logic [CntW-1:0]  match_o,
  output logic [CntW-1:0]  fill_o,
  output logic             full_o
);

  localparam logic [CntW-1:0] SlotsC = CntW'(SLOTS);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full_q, full_d;
  logic [CntW-1:0] idx_ext;
  logic [CntW-1:0] cnt_dec;
  hbtm_op_e        op;
  hbtm_status_e    status;

  assign op      = hbtm_op_e'(op_i);
  assign idx_ext = CntW'(idx_i);
  assign cnt_dec = cnt_q - 1'b1;
  assign last_o  = cnt_dec[IdxW-1:0];

  // Operation decode and next state
  always_comb begin
    cnt_d  = cnt_q;
    full_d = full_q;
    status = ST_OK;
    cmd_o  = '0;
    case (op)
      OP_INSERT: begin
        if (cnt_q >= SlotsC) begin
          status = ST_FULL;
        end else if (idx_ext != cnt_q) begin
          status = ST_NOT_NEXT;
        end else begin
          cmd_o.wr = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          if (cnt_d == SlotsC) full_d = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (idx_ext >= cnt_q) begin
          status = ST_NOT_OCC;
        end else begin
          cmd_o.mv = 1'b1;
          cnt_d    = cnt_dec;
        end
      end
      OP_FIND: ;
      OP_CLEAR: begin
        cmd_o.clr = 1'b1;
        cnt_d     = '0;
        full_d    = 1'b0;
      end
      default: ;
    endcase
    if (!en_i) cmd_o = '0;
  end

  // Lowest hitting slot wins; SLOTS when none or not a find
  always_comb begin
    match_o = SlotsC;
    if (op == OP_FIND) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (hit_i[i]) match_o = CntW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else if (en_i) begin
      cnt_q  <= cnt_d;
      full_q <= full_d;
    end
  end

  assign cnt_o    = cnt_q;
  assign status_o = status;
  assign fill_o   = cnt_d;
  assign full_o   = full_d;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: hash bucket tag match testbench
// Drives insert, remove, find and clear requests through the valid/ready
// request channel. Each accepted transfer runs through a behavioral model of
// the eight-slot bucket, and the response side is checked field by field in
// order. Directed tests cover the bucket rules; random traffic with sender
// gaps and receiver stalls covers the rest.
// ----------------------------------------------------------------------------
module tb;
  import hbtm_pkg::*;

  localparam int SLOTS      = 8;
  localparam int TAG_W      = 7;
  localparam int IDLE_LIMIT = 2000;

  // Expected response for one request
  typedef struct {
    hbtm_status_e status;
    logic [3:0]   match;
    logic [3:0]   fill;
    logic         was_full;
  } bucket_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [2:0]  slot_index_i;
  logic [31:0] key_hash_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [3:0]  match_index_o;
  logic [3:0]  fill_count_o;
  logic        was_full_o;

  // Bucket model state
  int unsigned       bucket_count;
  logic              bucket_was_full;
  logic [TAG_W-1:0]  bucket_tag  [SLOTS];
  logic [31:0]       bucket_hash [SLOTS];

  bucket_resp_t resp_pending[$];

  // Sender burst control
  bit gaps_on;
  int gap_max;
  int burst_left;

  // Receiver control
  int rx_mode;
  int hold_req;

  // Run statistics
  int err_count;
  int resp_count;
  int idle_cycles;
  int op_count     [4];
  int status_count [4];
  int full_hits;

  always #5 clk_i = ~clk_i;

  hash_bucket_tag_match uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .slot_index_i  (slot_index_i),
    .key_hash_i    (key_hash_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .match_index_o (match_index_o),
    .fill_count_o  (fill_count_o),
    .was_full_o    (was_full_o)
  );

  // --------------------------------------------------------------------------
  // Bucket model
  // --------------------------------------------------------------------------
  function automatic void clear_bucket();
    bucket_count    = 0;
    bucket_was_full = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      bucket_tag[i]  = '0;
      bucket_hash[i] = '0;
    end
  endfunction

  function automatic bucket_resp_t apply_request(hbtm_op_e op, logic [2:0] idx,
                                                 logic [31:0] hash);
    bucket_resp_t r;
    int unsigned  last;
    r.status = ST_OK;
    r.match  = 4'(SLOTS);
    case (op)
      OP_INSERT: begin
        if (bucket_count >= SLOTS) begin
          r.status = ST_FULL;
        end else if (idx != bucket_count) begin
          r.status = ST_NOT_NEXT;
        end else begin
          bucket_tag[idx]  = hash[TAG_W-1:0];
          bucket_hash[idx] = hash;
          bucket_count++;
          if (bucket_count == SLOTS) begin
            bucket_was_full = 1'b1;
            full_hits++;
          end
        end
      end
      OP_REMOVE: begin
        if (idx >= bucket_count) begin
          r.status = ST_NOT_OCC;
        end else begin
          // swap-remove: last occupied slot fills the hole
          last             = bucket_count - 1;
          bucket_tag[idx]  = bucket_tag[last];
          bucket_hash[idx] = bucket_hash[last];
          bucket_count     = last;
        end
      end
      OP_FIND: begin
        // scan downward so the lowest hit is left standing
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (i < bucket_count && bucket_tag[i] == hash[TAG_W-1:0] &&
              bucket_hash[i] == hash) begin
            r.match = 4'(i);
          end
        end
      end
      default: clear_bucket();
    endcase
    r.fill     = 4'(bucket_count);
    r.was_full = bucket_was_full;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Error reporting
  // --------------------------------------------------------------------------
  task automatic report_error(string msg);
    $display("tb: ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request side: one transfer, with burst gaps in front when enabled
  // --------------------------------------------------------------------------
  task automatic send_item(hbtm_op_e op, logic [2:0] idx, logic [31:0] hash);
    bucket_resp_t r;
    if (gaps_on && burst_left <= 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i   = 1'b1;
    op_i         = op;
    slot_index_i = idx;
    key_hash_i   = hash;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_request(op, idx, hash);
    resp_pending.push_back(r);
    op_count[op]++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (resp_pending.size() != 0) @(negedge clk_i);
  endtask

  // Random request shaped by the current bucket contents
  task automatic send_random();
    int          sel;
    logic [2:0]  idx;
    logic [31:0] hash;
    hbtm_op_e    op;
    sel  = $urandom_range(0, 99);
    hash = $urandom();
    idx  = 3'($urandom_range(0, SLOTS - 1));
    if (sel < 40) begin
      op = OP_INSERT;
      if (bucket_count < SLOTS && $urandom_range(0, 9) != 0) idx = 3'(bucket_count);
      // reuse a stored tag with new upper bits to force tag collisions
      if (bucket_count > 0 && $urandom_range(0, 3) == 0)
        hash[TAG_W-1:0] = bucket_tag[$urandom_range(0, bucket_count - 1)];
      if ($urandom_range(0, 19) == 0) hash = $urandom_range(0, 1) ? '1 : '0;
    end else if (sel < 60) begin
      op = OP_REMOVE;
      if (bucket_count > 0 && $urandom_range(0, 6) != 0)
        idx = 3'($urandom_range(0, bucket_count - 1));
    end else if (sel < 92) begin
      op = OP_FIND;
      if (bucket_count > 0) begin
        case ($urandom_range(0, 4))
          0, 1, 2: hash = bucket_hash[$urandom_range(0, bucket_count - 1)];
          3: hash[TAG_W-1:0] = bucket_tag[$urandom_range(0, bucket_count - 1)];
          default: ;
        endcase
      end
    end else if (sel < 98) begin
      // noise: any op, any fields
      op = hbtm_op_e'($urandom_range(0, 3));
    end else begin
      op = OP_CLEAR;
    end
    send_item(op, idx, hash);
  endtask

  // --------------------------------------------------------------------------
  // Response side: stall pattern, with a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int          hold_left;
    int          reload;
    logic [11:0] rx_pat;
    hold_left   = 0;
    reload      = 0;
    rx_pat      = 12'hB5D;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (++reload >= 96) begin
        reload = 0;
        rx_pat = $urandom_range(1, 4095);
      end
      rx_pat = {rx_pat[0], rx_pat[11:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = rx_pat[0];
          default: out_ready_i = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bucket_resp_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid_o && out_ready_i) begin
        resp_count++;
        if (resp_pending.size() == 0) begin
          report_error($sformatf("unexpected response, status %0d", status_o));
        end else begin
          e = resp_pending.pop_front();
          status_count[e.status]++;
          if (status_o !== e.status)
            report_error($sformatf("response %0d status got %0d exp %0d",
                                   resp_count, status_o, e.status));
          if (match_index_o !== e.match)
            report_error($sformatf("response %0d match_index got %0d exp %0d",
                                   resp_count, match_index_o, e.match));
          if (fill_count_o !== e.fill)
            report_error($sformatf("response %0d fill_count got %0d exp %0d",
                                   resp_count, fill_count_o, e.fill));
          if (was_full_o !== e.was_full)
            report_error($sformatf("response %0d was_full got %0d exp %0d",
                                   resp_count, was_full_o, e.was_full));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: timeout, no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty-bucket errors, fill to full, full insert, lookups at the extremes
  task automatic test_fill_and_errors();
    send_item(OP_FIND, 3'd0, 32'h0000_0000);
    send_item(OP_REMOVE, 3'd0, 32'h0);
    send_item(OP_INSERT, 3'd1, 32'h1234_5678);
    send_item(OP_INSERT, 3'd0, 32'h0000_0000);
    send_item(OP_INSERT, 3'd1, 32'hFFFF_FFFF);
    for (int i = 2; i < SLOTS; i++) send_item(OP_INSERT, 3'(i), $urandom());
    send_item(OP_INSERT, 3'd7, 32'hA5A5_A5A5);
    send_item(OP_FIND, 3'd5, 32'hFFFF_FFFF);
    send_item(OP_FIND, 3'd0, 32'h0000_0000);
  endtask

  // Last-slot drop, swap-remove, remove past the count, sticky flag
  task automatic test_remove_rules();
    logic [31:0] moved;
    moved = bucket_hash[SLOTS - 2];
    send_item(OP_REMOVE, 3'd7, 32'h0);
    send_item(OP_REMOVE, 3'd1, 32'h0);
    send_item(OP_FIND, 3'd0, moved);
    send_item(OP_REMOVE, 3'd6, 32'h0);
    send_item(OP_REMOVE, 3'd7, 32'h0);
  endtask

  // Shared tags with different hashes, duplicate hashes, clear drops the flag
  task automatic test_tag_collisions();
    send_item(OP_CLEAR, 3'd0, 32'h0);
    send_item(OP_INSERT, 3'd0, 32'h1111_1155);
    send_item(OP_INSERT, 3'd1, 32'h2222_2255);
    send_item(OP_INSERT, 3'd2, 32'h2222_2255);
    send_item(OP_FIND, 3'd0, 32'h2222_2255);
    send_item(OP_FIND, 3'd0, 32'h3333_3355);
    send_item(OP_CLEAR, 3'd0, 32'h0);
  endtask

  // Receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    rx_mode  = 0;
    hold_req = 60;
    repeat (24) send_random();
    wait_drained();
  endtask

  // Random traffic in phases with different gap and stall settings
  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on    = (ph != 0) && ($urandom_range(0, 3) != 0);
      gap_max    = $urandom_range(1, 8);
      burst_left = 0;
      rx_mode    = (ph == 0) ? 0 : $urandom_range(0, 2);
      repeat (300) send_random();
      if ($urandom_range(0, 1)) wait_drained();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OP_INSERT;
    slot_index_i = '0;
    key_hash_i   = '0;
    gaps_on      = 1'b1;
    gap_max      = 3;
    burst_left   = 0;
    rx_mode      = 1;
    hold_req     = 0;
    err_count    = 0;
    resp_count   = 0;
    idle_cycles  = 0;
    full_hits    = 0;
    for (int i = 0; i < 4; i++) begin
      op_count[i]     = 0;
      status_count[i] = 0;
    end
    clear_bucket();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_fill_and_errors();
    test_remove_rules();
    test_tag_collisions();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("tb: %0d requests (%0d insert, %0d remove, %0d find, %0d clear), %0d checked",
             op_count[OP_INSERT] + op_count[OP_REMOVE] + op_count[OP_FIND] +
             op_count[OP_CLEAR], op_count[OP_INSERT], op_count[OP_REMOVE],
             op_count[OP_FIND], op_count[OP_CLEAR], resp_count);
    $display("tb: status ok %0d, full %0d, not next %0d, not occupied %0d; filled %0d times",
             status_count[ST_OK], status_count[ST_FULL], status_count[ST_NOT_NEXT],
             status_count[ST_NOT_OCC], full_hits);
    if (err_count == 0 && resp_pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/hbtm_pkg.sv
hw/rtl/hbtm_slot_array.sv
hw/rtl/hbtm_ctrl.sv
hw/rtl/hash_bucket_tag_match.sv
tb/tb.sv
